[sv/rtg_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and sizes of the pre-trade risk gate
package rtg_pkg;

	localparam int BLACKLIST_DEPTH_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam int CMD_W = 3;
	localparam int KEY_W = 64;
	localparam int PRICE_W = 32;
	localparam int QTY_W = 32;
	localparam int VALUE_W = 64;
	localparam int VERDICT_W = 3;
	localparam int LISTED_W = 7;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL_BIT = 3;

	// register select, taken from paddr bit REG_SEL_BIT
	localparam logic REG_VALUE_LIMIT = 1'b0;
	localparam logic REG_ENGINE_ENABLED = 1'b1;

	localparam logic [CMD_W-1:0] CMD_CHECK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRIP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESET = 3'd4;

	localparam logic [VERDICT_W-1:0] VERDICT_APPROVED = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_ORDER_SIZE = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_BLACKLIST = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_BREAKER = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_SYS_ERROR = 3'd4;

	localparam logic [VALUE_W-1:0] VALUE_LIMIT_RST = '1;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [KEY_W-1:0]   symbol_key;
		logic [PRICE_W-1:0] price_ticks;
		logic [QTY_W-1:0]   order_quantity;
	} in_word_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic                 table_full;
		logic                 breaker_active;
		logic [LISTED_W-1:0]  listed_count;
	} out_word_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] symbol_key;
		logic             over_limit;
	} task_word_t;

	typedef struct packed {
		logic       valid;
		task_word_t word;
	} task_push_t;

endpackage

[sv/rtg_ram.sv]
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module rtg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/rtg_front.sv]
`timescale 1ns / 1ps
// front: takes input words, forms the order value and flags it against the limit
module rtg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rtg_pkg::in_word_t              in_word,
	input  logic [rtg_pkg::VALUE_W-1:0]    value_limit,
	output rtg_pkg::task_push_t            push,
	input  logic                           queue_full
);
	import rtg_pkg::*;

	logic               vld_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [VALUE_W-1:0] prod_s1;
	logic [VALUE_W-1:0] prod_d;

	// 32 x 32 product, exact in 64 bits
	assign prod_d = VALUE_W'(in_word.price_ticks) * VALUE_W'(in_word.order_quantity);

	assign in_stall = vld_s1 && queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= in_word.cmd;
			key_s1  <= in_word.symbol_key;
			prod_s1 <= prod_d;
		end
	end

	always_comb begin
		push.valid           = vld_s1 && !queue_full;
		push.word.cmd        = cmd_s1;
		push.word.symbol_key = key_s1;
		push.word.over_limit = prod_s1 > value_limit;
	end

endmodule

[sv/rtg_queue.sv]
`timescale 1ns / 1ps
// short fifo between front and back
module rtg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rtg_pkg::task_push_t   push,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output rtg_pkg::task_word_t   head
);
	import rtg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	task_word_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.word;
		end
	end

endmodule

[sv/rtg_back.sv]
`timescale 1ns / 1ps
// back: scans the blacklist, applies the command and holds the result word
module rtg_back #(
	parameter int BLACKLIST_DEPTH = rtg_pkg::BLACKLIST_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  rtg_pkg::task_word_t  q_head,
	output logic                 q_pop,
	input  logic                 engine_enabled,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rtg_pkg::out_word_t   out_word
);
	import rtg_pkg::*;

	localparam int IDX_W = (BLACKLIST_DEPTH > 1) ? $clog2(BLACKLIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(BLACKLIST_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLACKLIST_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BLACKLIST_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           issue_cnt_q;
	logic                       cmp_vld_q;
	logic [IDX_W-1:0]           cmp_idx_q;
	logic                       hit_q;
	logic                       free_q;
	logic [BLACKLIST_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]           count_q;
	logic                       breaker_q;
	logic                       out_vld_q;
	out_word_t                  out_q;

	task_word_t                 cur_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [IDX_W-1:0]           free_idx_q;

	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic [KEY_W-1:0]           rd_data;
	logic                       cmp_hit;
	logic                       cmp_free;
	logic                       scan_last;
	logic                       need_scan;
	logic                       out_free;
	logic                       do_finish;
	logic                       add_ok;
	logic                       rm_ok;
	logic                       breaker_next;
	logic [CNT_W-1:0]           count_next;
	logic [VERDICT_W-1:0]       verdict;
	logic                       table_full;

	rtg_ram #(
		.WIDTH (KEY_W),
		.DEPTH (BLACKLIST_DEPTH)
	) u_keys (
		.clk     (clk),
		.wr_en   (do_finish && add_ok),
		.wr_addr (free_idx_q),
		.wr_data (cur_q.symbol_key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one key read issued per cycle, compared in the following cycle
	assign rd_en     = (state_q == S_SCAN) && (issue_cnt_q < DEPTH_CNT);
	assign rd_addr   = issue_cnt_q[IDX_W-1:0];
	assign cmp_hit   = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data == cur_q.symbol_key);
	assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];
	assign scan_last = cmp_vld_q && (cmp_idx_q == LAST_IDX);

	// a check decided before the blacklist step needs no scan
	assign need_scan = (q_head.cmd == CMD_ADD) || (q_head.cmd == CMD_REMOVE) ||
	                   ((q_head.cmd == CMD_CHECK) && engine_enabled && !q_head.over_limit);

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign out_free  = !out_vld_q || !out_stall;
	assign do_finish = (state_q == S_FINISH) && out_free;
	assign add_ok    = (cur_q.cmd == CMD_ADD) && !hit_q && free_q;
	assign rm_ok     = (cur_q.cmd == CMD_REMOVE) && hit_q;

	always_comb begin
		verdict      = VERDICT_APPROVED;
		table_full   = 1'b0;
		breaker_next = breaker_q;
		count_next   = count_q;
		case (cur_q.cmd)
			CMD_CHECK: begin
				if (!engine_enabled) begin
					verdict = VERDICT_SYS_ERROR;
				end else if (cur_q.over_limit) begin
					verdict = VERDICT_ORDER_SIZE;
				end else if (hit_q) begin
					verdict = VERDICT_BLACKLIST;
				end else if (breaker_q) begin
					verdict = VERDICT_BREAKER;
				end
			end
			CMD_ADD: begin
				table_full = !hit_q && !free_q;
				if (add_ok) begin
					count_next = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (rm_ok) begin
					count_next = count_q - 1'b1;
				end
			end
			CMD_TRIP:  breaker_next = 1'b1;
			CMD_RESET: breaker_next = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_cnt_q <= '0;
			cmp_vld_q   <= 1'b0;
			cmp_idx_q   <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			breaker_q   <= 1'b0;
			out_vld_q   <= 1'b0;
			out_q       <= '0;
		end else begin
			if (do_finish) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						issue_cnt_q <= '0;
						cmp_vld_q   <= 1'b0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						state_q     <= need_scan ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					cmp_vld_q <= rd_en;
					if (rd_en) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
						cmp_idx_q   <= rd_addr;
					end
					hit_q  <= hit_q | cmp_hit;
					free_q <= free_q | cmp_free;
					if (scan_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						if (add_ok) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (rm_ok) begin
							valid_q[hit_idx_q] <= 1'b0;
						end
						count_q                <= count_next;
						breaker_q              <= breaker_next;
						out_q.verdict          <= verdict;
						out_q.table_full       <= table_full;
						out_q.breaker_active   <= breaker_next;
						out_q.listed_count     <= LISTED_W'(count_next);
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (state_q == S_SCAN) begin
			if (cmp_hit && !hit_q) begin
				hit_idx_q <= cmp_idx_q;
			end
			// lowest free entry wins
			if (cmp_free && !free_q) begin
				free_idx_q <= cmp_idx_q;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("entry count differs from number of valid entries");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count above table depth");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && hit_q |-> valid_q[hit_idx_q])
		else $error("matched entry is not valid");

endmodule

[sv/pre_trade_risk_gate_top.sv]
`timescale 1ns / 1ps
// path: the input word is registered in the front, queued, then popped by the back; blacklist
//   add, remove and checks that reach the blacklist step scan every entry before the result word
// the back takes one word at a time; a scan compares one entry per cycle through the key ram
//   read port, while later input words wait in the front register and the queue
// reset: breaker clear, blacklist empty (valid bits cleared at once, no sweep),
//   order value limit all ones, engine_enabled 1
module pre_trade_risk_gate_top #(
	parameter int BLACKLIST_DEPTH = rtg_pkg::BLACKLIST_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtg_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rtg_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rtg_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rtg_pkg::in_word_t                 in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rtg_pkg::out_word_t                out_word
);
	import rtg_pkg::*;

	logic [VALUE_W-1:0] value_limit_q;
	logic               engine_enabled_q;
	logic               reg_wr;
	task_push_t         push;
	logic               queue_full;
	logic               q_pop;
	logic               q_empty;
	task_word_t         q_head;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_limit_q    <= VALUE_LIMIT_RST;
			engine_enabled_q <= 1'b1;
		end else if (reg_wr) begin
			case (paddr[REG_SEL_BIT])
				REG_VALUE_LIMIT:    value_limit_q    <= pwdata;
				REG_ENGINE_ENABLED: engine_enabled_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_VALUE_LIMIT:    prdata = value_limit_q;
			REG_ENGINE_ENABLED: prdata = APB_DATA_W'(engine_enabled_q);
			default:            prdata = '0;
		endcase
	end

	rtg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.value_limit (value_limit_q),
		.push        (push),
		.queue_full  (queue_full)
	);

	rtg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	rtg_back #(
		.BLACKLIST_DEPTH (BLACKLIST_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.engine_enabled (engine_enabled_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_word       (out_word)
	);

endmodule

[tb/sv/tb_pre_trade_risk_gate_top.sv]
`timescale 1ns / 1ps
// self-checking bench for the pre-trade risk gate: order checks, blacklist and breaker words
module tb_pre_trade_risk_gate_top;
	import rtg_pkg::*;

	localparam int DEPTH = BLACKLIST_DEPTH_DEF;
	localparam int POOL_N = 80;
	localparam int HOLD_CYCLES = 400;
	localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT = APB_ADDR_W'(REG_VALUE_LIMIT) << REG_SEL_BIT;
	localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE =
		APB_ADDR_W'(REG_ENGINE_ENABLED) << REG_SEL_BIT;
	localparam logic [CMD_W-1:0] CMD_TOP = '1;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [PRICE_W-1:0] AMT_ONES = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;

	pre_trade_risk_gate_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always #1 clk = ~clk;

	// gate state as the bench sees it
	logic [VALUE_W-1:0] lim_value = VALUE_LIMIT_RST;
	logic engine_on = 1'b1;
	logic [KEY_W-1:0] bl_key [DEPTH];
	logic bl_used [DEPTH];
	logic brk_on = 1'b0;
	logic [LISTED_W-1:0] listed_n = '0;

	// both queues fill at the front and drain at the back
	in_word_t order_q [$];
	out_word_t verdict_q [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int gap_max = 11;
	int stall_max = 11;
	int gap_left = 0;
	int stall_left = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int bad_count = 0;
	int words_in = 0;
	int verdict_tally [5];
	int full_tally = 0;
	int peak_listed = 0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			bl_used[i] = 1'b0;
			bl_key[i] = '0;
		end
		for (int i = 0; i < 5; i++)
			verdict_tally[i] = 0;
	end

	// applies one accepted word to the bench state and returns the word it must produce
	function automatic out_word_t screen_order(in_word_t w);
		out_word_t r;
		int hit;
		int slot;
		logic [VALUE_W-1:0] value;
		r = '0;
		hit = -1;
		slot = -1;
		for (int i = DEPTH - 1; i >= 0; i--)
			if (bl_used[i] && bl_key[i] == w.symbol_key)
				hit = i;
		case (w.cmd)
			CMD_CHECK: begin
				value = {32'd0, w.price_ticks} * {32'd0, w.order_quantity};
				if (!engine_on)
					r.verdict = VERDICT_SYS_ERROR;
				else if (value > lim_value)
					r.verdict = VERDICT_ORDER_SIZE;
				else if (hit >= 0)
					r.verdict = VERDICT_BLACKLIST;
				else if (brk_on)
					r.verdict = VERDICT_BREAKER;
				else
					r.verdict = VERDICT_APPROVED;
				verdict_tally[r.verdict]++;
			end
			CMD_ADD: begin
				if (hit < 0) begin
					// lowest free entry takes the key
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!bl_used[i])
							slot = i;
					if (slot < 0) begin
						r.table_full = 1'b1;
						full_tally++;
					end else begin
						bl_used[slot] = 1'b1;
						bl_key[slot] = w.symbol_key;
						listed_n = listed_n + 1'b1;
					end
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					bl_used[hit] = 1'b0;
					listed_n = listed_n - 1'b1;
				end
			end
			CMD_TRIP: brk_on = 1'b1;
			CMD_RESET: brk_on = 1'b0;
			default: ;
		endcase
		if (int'(listed_n) > peak_listed)
			peak_listed = int'(listed_n);
		r.breaker_active = brk_on;
		r.listed_count = listed_n;
		return r;
	endfunction

	function automatic void queue_order(in_word_t w);
		order_q.push_front(w);
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				verdict_q.push_front(screen_order(in_word));
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (order_q.size() != 0) begin
					in_word <= order_q.pop_back();
					in_valid <= 1'b1;
					gap_left <= $urandom_range(0, gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and result check
	always @(posedge clk) begin : rx_side
		int d;
		out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected result word: %p", out_word);
				end else begin
					want = verdict_q.pop_back();
					if (out_word.verdict !== want.verdict
							|| out_word.table_full !== want.table_full
							|| out_word.breaker_active !== want.breaker_active
							|| out_word.listed_count !== want.listed_count) begin
						bad_count++;
						if (bad_count <= 10)
							$display({"mismatch: verdict %0d/%0d full %0d/%0d ",
								"breaker %0d/%0d listed %0d/%0d (exp/act)"},
								want.verdict, out_word.verdict,
								want.table_full, out_word.table_full,
								want.breaker_active, out_word.breaker_active,
								want.listed_count, out_word.listed_count);
					end
				end
			end
			if (hold_asked != hold_done) begin
				hold_done <= hold_asked;
				stall_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				d = $urandom_range(0, stall_max);
				stall_left <= (d != 0) ? d - 1 : 0;
				out_stall <= (d != 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_word_t mk(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
			logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
		in_word_t w;
		w.cmd = c;
		w.symbol_key = k;
		w.price_ticks = p;
		w.order_quantity = q;
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		if ($urandom_range(0, 19) == 0)
			return {$urandom, $urandom};
		return key_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 16'hFFFF);
			2: begin
				case ($urandom_range(0, 2))
					0: return 32'd0;
					1: return 32'd1;
					default: return AMT_ONES;
				endcase
			end
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic in_word_t rand_item(int add_pct, int rem_pct);
		int r;
		logic [CMD_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			c = CMD_ADD;
		else if (r < add_pct + rem_pct)
			c = CMD_REMOVE;
		else if (r < add_pct + rem_pct + 4)
			c = CMD_TRIP;
		else if (r < add_pct + rem_pct + 8)
			c = CMD_RESET;
		else if (r < add_pct + rem_pct + 11)
			c = CMD_W'($urandom_range(int'(CMD_RESET) + 1, int'(CMD_TOP)));
		else
			c = CMD_CHECK;
		return mk(c, rand_key(), rand_amount(), rand_amount());
	endfunction

	task automatic drain();
		while (order_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] a,
			input logic [APB_DATA_W-1:0] d, output logic [APB_DATA_W-1:0] rd);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write both registers while the gate is idle, then read them back
	task automatic reconfigure(input logic [VALUE_W-1:0] lim, input logic en);
		logic [APB_DATA_W-1:0] rd;
		logic [APB_DATA_W-1:0] en_word;
		drain();
		repeat (4) @(posedge clk);
		en_word = {{(APB_DATA_W - 1){1'b0}}, en};
		apb_access(1'b1, ADDR_LIMIT, lim, rd);
		apb_access(1'b1, ADDR_ENABLE, en_word, rd);
		lim_value = lim;
		engine_on = en;
		apb_access(1'b0, ADDR_LIMIT, '0, rd);
		if (rd !== lim) begin
			bad_count++;
			if (bad_count <= 10)
				$display("order value limit readback: exp %h act %h", lim, rd);
		end
		apb_access(1'b0, ADDR_ENABLE, '0, rd);
		if (rd !== en_word) begin
			bad_count++;
			if (bad_count <= 10)
				$display("engine_enabled readback: exp %h act %h", en_word, rd);
		end
	endtask

	task automatic run_random(int n, int add_pct, int rem_pct, int gmax, int smax);
		gap_max <= gmax;
		stall_max <= smax;
		for (int i = 0; i < n; i++)
			queue_order(rand_item(add_pct, rem_pct));
		drain();
	endtask

	initial begin
		logic [PRICE_W-1:0] p;
		logic [QTY_W-1:0] q;
		logic [VALUE_W-1:0] prod;
		key_pool[0] = '0;
		key_pool[1] = KEY_ONES;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		reconfigure(VALUE_LIMIT_RST, 1'b1);

		// directed: field extremes, duplicates, priorities, unknown commands
		queue_order(mk(CMD_CHECK, '0, '0, '0));
		queue_order(mk(CMD_CHECK, KEY_ONES, AMT_ONES, AMT_ONES));
		queue_order(mk(CMD_ADD, KEY_ONES, '0, '0));
		queue_order(mk(CMD_ADD, KEY_ONES, $urandom, $urandom));
		queue_order(mk(CMD_CHECK, KEY_ONES, 32'd1, 32'd1));
		queue_order(mk(CMD_ADD, '0, AMT_ONES, AMT_ONES));
		queue_order(mk(CMD_TRIP, KEY_W'($urandom), $urandom, $urandom));
		queue_order(mk(CMD_CHECK, {$urandom, $urandom}, 32'd3, 32'd7));
		queue_order(mk(CMD_CHECK, '0, 32'd1, 32'd1));
		queue_order(mk(CMD_REMOVE, '0, '0, '0));
		queue_order(mk(CMD_REMOVE, '0, '0, '0));
		queue_order(mk(CMD_RESET + 1'b1, {$urandom, $urandom}, $urandom, $urandom));
		queue_order(mk(CMD_TOP, KEY_ONES, AMT_ONES, AMT_ONES));
		queue_order(mk(CMD_RESET, '0, '0, '0));
		queue_order(mk(CMD_CHECK, '0, 32'd2, 32'd5));

		// zero limit: only a zero product passes, size beats blacklist
		reconfigure('0, 1'b1);
		queue_order(mk(CMD_CHECK, '0, '0, AMT_ONES));
		queue_order(mk(CMD_CHECK, '0, 32'd1, 32'd1));
		queue_order(mk(CMD_CHECK, KEY_ONES, 32'd1, 32'd1));

		// engine off: checks are system errors, table and breaker still act
		reconfigure(VALUE_LIMIT_RST, 1'b0);
		queue_order(mk(CMD_CHECK, KEY_ONES, '0, '0));
		queue_order(mk(CMD_ADD, '0, '0, '0));
		queue_order(mk(CMD_TRIP, '0, '0, '0));
		queue_order(mk(CMD_CHECK, {$urandom, $urandom}, AMT_ONES, AMT_ONES));
		queue_order(mk(CMD_RESET, '0, '0, '0));

		// limit boundary: product equal to the limit passes, one above fails
		p = $urandom | 32'd1;
		q = $urandom | 32'd1;
		prod = {32'd0, p} * {32'd0, q};
		reconfigure(prod, 1'b1);
		queue_order(mk(CMD_CHECK, {$urandom, $urandom}, p, q));
		reconfigure(prod - 1'b1, 1'b1);
		queue_order(mk(CMD_CHECK, {$urandom, $urandom}, p, q));

		// fill the table past capacity while the output is held off
		reconfigure(VALUE_LIMIT_RST, 1'b1);
		gap_max <= 0;
		stall_max <= 0;
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 70; i++) begin
			queue_order(mk(CMD_ADD, key_pool[i], rand_amount(), rand_amount()));
			if (i % 4 == 3)
				queue_order(mk(CMD_CHECK, rand_key(), rand_amount(), rand_amount()));
		end
		queue_order(mk(CMD_ADD, key_pool[5], '0, '0));
		queue_order(mk(CMD_ADD, {$urandom, $urandom}, '0, '0));
		queue_order(mk(CMD_CHECK, key_pool[10], 32'd4, 32'd4));
		drain();

		reconfigure({32'd0, 1'b1, 31'($urandom)}, 1'b1);
		run_random(300, 10, 35, 11, 11);
		reconfigure(VALUE_LIMIT_RST, 1'b1);
		run_random(300, 25, 15, 0, 0);
		reconfigure({$urandom, $urandom}, 1'b0);
		run_random(200, 20, 20, 11, 11);
		reconfigure({16'd0, 16'($urandom), $urandom}, 1'b1);
		run_random(550, 20, 20, 11, 0);
		reconfigure(VALUE_LIMIT_RST, 1'b1);
		run_random(300, 30, 10, 0, 11);

		repeat (DEPTH + 10) @(posedge clk);
		$display({"run: %0d words; approved %0d, order size %0d, blacklist %0d, ",
			"breaker %0d, system error %0d"},
			words_in, verdict_tally[VERDICT_APPROVED], verdict_tally[VERDICT_ORDER_SIZE],
			verdict_tally[VERDICT_BLACKLIST], verdict_tally[VERDICT_BREAKER],
			verdict_tally[VERDICT_SYS_ERROR]);
		$display({"run: %0d adds into a full table, peak listed %0d, ",
			"%0d long output holds, %0d mismatches"},
			full_tally, peak_listed, hold_done, bad_count);
		if (bad_count == 0 && verdict_q.size() == 0)
			$display("tb_pre_trade_risk_gate_top: done, clean");
		else
			$display("tb_pre_trade_risk_gate_top: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d results still expected", verdict_q.size());
		$display("tb_pre_trade_risk_gate_top: done, errors");
		$finish;
	end

endmodule
